// ===== src/mctg_pkg.sv =====
`default_nettype none
package mctg_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int TIME_BITS   = 40;
	localparam int FRAC_BITS   = 16;
	localparam int FIX_BITS    = TIME_BITS + FRAC_BITS;
	localparam int PERIOD_BITS = 40;
	localparam int MAX_RESULTS = 5;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 64;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 40'd65536000;

	// song position = tick_total / 6, exact for any 32-bit count
	localparam logic [31:0] DIV6_RECIP = 32'hAAAA_AAAB;
	localparam int          DIV6_SHIFT = 34;

	// request types
	localparam logic [2:0] REQ_SAMPLE = 3'd0;
	localparam logic [2:0] REQ_START  = 3'd1;
	localparam logic [2:0] REQ_STOP   = 3'd2;
	localparam logic [2:0] REQ_PAUSE  = 3'd3;
	localparam logic [2:0] REQ_RESUME = 3'd4;

	// MIDI status bytes
	localparam logic [7:0] MSG_CLOCK = 8'hF8;
	localparam logic [7:0] MSG_START = 8'hFA;
	localparam logic [7:0] MSG_CONT  = 8'hFB;
	localparam logic [7:0] MSG_STOP  = 8'hFC;
	localparam logic [7:0] MSG_POS   = 8'hF2;

	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_THREE = 2'd3;

	// register index (paddr[3])
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_ENABLE = 1'b1;

	// queue push selections
	localparam logic [2:0] PUSH_STOP_NOW     = 3'd0;
	localparam logic [2:0] PUSH_POS_ANCHOR   = 3'd1;
	localparam logic [2:0] PUSH_START_ANCHOR = 3'd2;
	localparam logic [2:0] PUSH_POS_NOW      = 3'd3;
	localparam logic [2:0] PUSH_CONT_NOW     = 3'd4;

	typedef struct packed {
		logic [TIME_BITS-1:0] when;
		logic [7:0]           status;
		logic [6:0]           d1;
		logic [6:0]           d2;
		logic [1:0]           len;
	} qentry_t;

	typedef struct packed {
		logic       latch;
		logic       clr;
		logic       push;
		logic [2:0] push_sel;
		logic       anchor_ld;
		logic       start_set;
		logic       stop_set;
		logic       pause_set;
		logic       resume_set;
		logic       emit;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       clock_enable;
		logic       running;
		logic       paused;
		logic       found;
		logic       out_free;
		logic       pend_v;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/mctg_regs.sv =====
`default_nettype none
module mctg_regs (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [mctg_pkg::ADDR_W-1:0]         paddr,
	input  wire  [mctg_pkg::DATA_W-1:0]         pwdata,
	output logic [mctg_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	output logic [mctg_pkg::PERIOD_BITS-1:0]    tick_period,
	output logic                                clock_enable
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period  <= mctg_pkg::PERIOD_RESET;
			clock_enable <= 1'b0;
		end else if (wr_en) begin
			if (paddr[3] == mctg_pkg::REG_PERIOD) begin
				tick_period <= pwdata[mctg_pkg::PERIOD_BITS-1:0];
			end else begin
				clock_enable <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (paddr[3] == mctg_pkg::REG_ENABLE) begin
			prdata = mctg_pkg::DATA_W'(clock_enable);
		end else begin
			prdata = mctg_pkg::DATA_W'(tick_period);
		end
	end

endmodule
`default_nettype wire

// ===== src/mctg_ctrl.sv =====
`default_nettype none
module mctg_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_ready,
	input  mctg_pkg::stat_t    stat,
	output mctg_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_PUSH_A = 3'd2;
	localparam logic [2:0] ST_PUSH_B = 3'd3;
	localparam logic [2:0] ST_R_POS  = 3'd4;
	localparam logic [2:0] ST_R_CONT = 3'd5;
	localparam logic [2:0] ST_EVAL   = 3'd6;

	logic [2:0]                 state_q, state_d;
	logic [mctg_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic                       more;

	assign item_ready = (state_q == ST_IDLE);
	assign more       = stat.found && (cnt_q < mctg_pkg::CNT_W'(mctg_pkg::MAX_RESULTS));

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (stat.req_type)
					mctg_pkg::REQ_START: begin
						if (stat.clock_enable) begin
							cmd.clr       = 1'b1;
							cmd.anchor_ld = 1'b1;
							cmd.push      = stat.running;
							cmd.push_sel  = mctg_pkg::PUSH_STOP_NOW;
							state_d       = ST_PUSH_A;
						end
					end
					mctg_pkg::REQ_STOP: begin
						if (stat.running) begin
							cmd.clr      = 1'b1;
							cmd.push     = 1'b1;
							cmd.push_sel = mctg_pkg::PUSH_STOP_NOW;
							cmd.stop_set = 1'b1;
						end
					end
					mctg_pkg::REQ_PAUSE: begin
						if (stat.running && !stat.paused) begin
							cmd.clr       = 1'b1;
							cmd.push      = 1'b1;
							cmd.push_sel  = mctg_pkg::PUSH_STOP_NOW;
							cmd.pause_set = 1'b1;
						end
					end
					mctg_pkg::REQ_RESUME: begin
						if (stat.running && stat.paused) begin
							cmd.resume_set = 1'b1;
							state_d        = ST_R_POS;
						end
					end
					mctg_pkg::REQ_SAMPLE: begin
						cnt_d   = '0;
						state_d = ST_EVAL;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_PUSH_A: begin
				cmd.push     = 1'b1;
				cmd.push_sel = mctg_pkg::PUSH_POS_ANCHOR;
				state_d      = ST_PUSH_B;
			end
			ST_PUSH_B: begin
				cmd.push      = 1'b1;
				cmd.push_sel  = mctg_pkg::PUSH_START_ANCHOR;
				cmd.start_set = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_R_POS: begin
				cmd.push     = 1'b1;
				cmd.push_sel = mctg_pkg::PUSH_POS_NOW;
				state_d      = ST_R_CONT;
			end
			ST_R_CONT: begin
				cmd.push     = 1'b1;
				cmd.push_sel = mctg_pkg::PUSH_CONT_NOW;
				state_d      = ST_IDLE;
			end
			ST_EVAL: begin
				// wait while a held result cannot move on
				if (!stat.pend_v || stat.out_free) begin
					if (more) begin
						cmd.emit = 1'b1;
						cnt_d    = cnt_q + 1'b1;
					end else begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/mctg_datapath.sv =====
`default_nettype none
module mctg_datapath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  mctg_pkg::cmd_t                      cmd,
	output mctg_pkg::stat_t                     stat,
	input  wire  [2:0]                          req_type,
	input  wire  [15:0]                         start_delay,
	input  wire  [mctg_pkg::PERIOD_BITS-1:0]    tick_period,
	input  wire                                 clock_enable,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output logic [7:0]                          status_byte,
	output logic [6:0]                          data_one,
	output logic [6:0]                          data_two,
	output logic [1:0]                          byte_count,
	output logic                                last_in_run
);

	localparam int TB = mctg_pkg::TIME_BITS;
	localparam int FB = mctg_pkg::FIX_BITS;
	localparam int QW = mctg_pkg::QIDX_W;
	localparam int FW = mctg_pkg::FILL_W;

	// latched request
	logic [2:0]  req_q;
	logic [15:0] delay_q;

	// timing state
	logic [TB-1:0] now_q, anchor_q;
	logic [FB-1:0] ntt_q, phase_q;
	logic [31:0]   ticks_q;
	logic [63:0]   prod_q;
	logic          run_q, started_q, paused_q;

	// control queue
	mctg_pkg::qentry_t q_mem_q [mctg_pkg::QUEUE_DEPTH];
	logic [QW-1:0]     head_q;
	logic [FW-1:0]     fill_q;

	// held result and output register
	logic              pend_v_q, res_v_q;
	mctg_pkg::qentry_t pend_q, res_q;
	logic              res_last_q;

	logic [FB-1:0]     nowf, tick_fix;
	logic [TB-1:0]     tick_sec, anchor_d;
	logic [TB:0]       anchor_sum;
	mctg_pkg::qentry_t head_e, push_e, clk_e;
	logic              have_ctl, have_tick, pick_ctl, out_free, load_out;
	logic [QW-1:0]     base_head, tail, head_nx;
	logic [FW-1:0]     base_fill;
	logic [QW:0]       tail_sum;

	assign nowf       = {now_q, {mctg_pkg::FRAC_BITS{1'b0}}};
	assign tick_sec   = ntt_q[FB-1:mctg_pkg::FRAC_BITS];
	assign tick_fix   = ntt_q + FB'(tick_period);
	assign anchor_sum = {1'b0, now_q} + (TB+1)'(delay_q);
	assign anchor_d   = anchor_sum[TB] ? {TB{1'b1}} : anchor_sum[TB-1:0];

	assign head_e    = q_mem_q[head_q];
	assign have_ctl  = (fill_q != '0) && (head_e.when <= now_q);
	assign have_tick = run_q && started_q && !paused_q && (tick_sec <= now_q);
	assign pick_ctl  = have_ctl && (!have_tick || (head_e.when <= tick_sec));

	assign out_free = !res_v_q || result_ready;
	assign load_out = pend_v_q && (cmd.emit || cmd.finish);

	assign head_nx  = (head_q == QW'(mctg_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// push slot, clear taking effect first
	assign base_head = cmd.clr ? '0 : head_q;
	assign base_fill = cmd.clr ? '0 : fill_q;
	assign tail_sum  = (QW+1)'(base_head) + (QW+1)'(base_fill);
	assign tail      = (tail_sum >= (QW+1)'(mctg_pkg::QUEUE_DEPTH)) ?
	                   QW'(tail_sum - (QW+1)'(mctg_pkg::QUEUE_DEPTH)) : tail_sum[QW-1:0];

	assign clk_e = '{when: '0, status: mctg_pkg::MSG_CLOCK, d1: '0, d2: '0,
	                 len: mctg_pkg::LEN_ONE};

	always_comb begin
		push_e = '{when: now_q, status: mctg_pkg::MSG_STOP, d1: '0, d2: '0,
		           len: mctg_pkg::LEN_ONE};
		case (cmd.push_sel)
			mctg_pkg::PUSH_STOP_NOW: begin
				push_e.status = mctg_pkg::MSG_STOP;
			end
			mctg_pkg::PUSH_POS_ANCHOR: begin
				push_e.when   = anchor_q;
				push_e.status = mctg_pkg::MSG_POS;
				push_e.len    = mctg_pkg::LEN_THREE;
			end
			mctg_pkg::PUSH_START_ANCHOR: begin
				push_e.when   = anchor_q;
				push_e.status = mctg_pkg::MSG_START;
			end
			mctg_pkg::PUSH_POS_NOW: begin
				push_e.status = mctg_pkg::MSG_POS;
				push_e.d1     = prod_q[mctg_pkg::DIV6_SHIFT +: 7];
				push_e.d2     = prod_q[mctg_pkg::DIV6_SHIFT + 7 +: 7];
				push_e.len    = mctg_pkg::LEN_THREE;
			end
			mctg_pkg::PUSH_CONT_NOW: begin
				push_e.status = mctg_pkg::MSG_CONT;
			end
			default: begin
				push_e.status = mctg_pkg::MSG_STOP;
			end
		endcase
	end

	assign stat = '{req_type: req_q, clock_enable: clock_enable, running: run_q,
	                paused: paused_q, found: have_ctl || have_tick, out_free: out_free,
	                pend_v: pend_v_q};

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q   <= req_type;
			delay_q <= start_delay;
		end
		if (cmd.anchor_ld) begin
			anchor_q <= anchor_d;
		end
		if (cmd.resume_set) begin
			prod_q <= ticks_q * mctg_pkg::DIV6_RECIP;
		end
		if (cmd.pause_set) begin
			phase_q <= (ntt_q > nowf) ? ntt_q - nowf : '0;
		end
		if (cmd.push && (base_fill != FW'(mctg_pkg::QUEUE_DEPTH))) begin
			q_mem_q[tail] <= push_e;
		end
		if (cmd.emit) begin
			pend_q <= pick_ctl ? head_e : clk_e;
		end
		if (load_out) begin
			res_q      <= pend_q;
			res_last_q <= cmd.finish;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			ntt_q     <= '0;
			ticks_q   <= '0;
			run_q     <= 1'b0;
			started_q <= 1'b0;
			paused_q  <= 1'b0;
			head_q    <= '0;
			fill_q    <= '0;
			pend_v_q  <= 1'b0;
			res_v_q   <= 1'b0;
		end else begin
			if (cmd.clr || cmd.push) begin
				head_q <= base_head;
				if (cmd.push && (base_fill != FW'(mctg_pkg::QUEUE_DEPTH))) begin
					fill_q <= base_fill + 1'b1;
				end else begin
					fill_q <= base_fill;
				end
			end
			if (cmd.start_set) begin
				run_q     <= 1'b1;
				started_q <= 1'b0;
				paused_q  <= 1'b0;
				ntt_q     <= {anchor_q, {mctg_pkg::FRAC_BITS{1'b0}}};
				ticks_q   <= '0;
			end
			if (cmd.stop_set) begin
				run_q     <= 1'b0;
				started_q <= 1'b0;
				paused_q  <= 1'b0;
			end
			if (cmd.pause_set) begin
				paused_q <= 1'b1;
			end
			if (cmd.resume_set) begin
				paused_q  <= 1'b0;
				started_q <= 1'b0;
				ntt_q     <= nowf + phase_q;
			end
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
				if (pick_ctl) begin
					head_q <= head_nx;
					fill_q <= fill_q - 1'b1;
					if ((head_e.status == mctg_pkg::MSG_START) ||
					    (head_e.status == mctg_pkg::MSG_CONT)) begin
						started_q <= 1'b1;
					end else if (head_e.status == mctg_pkg::MSG_STOP) begin
						started_q <= 1'b0;
					end
				end else begin
					ticks_q <= ticks_q + 1'b1;
					ntt_q   <= tick_fix;
				end
			end
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
				now_q    <= now_q + 1'b1;
			end
			if (load_out) begin
				res_v_q <= 1'b1;
			end else if (result_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_v_q;
	assign status_byte  = res_q.status;
	assign data_one     = res_q.d1;
	assign data_two     = res_q.d2;
	assign byte_count   = res_q.len;
	assign last_in_run  = res_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(mctg_pkg::QUEUE_DEPTH))
		else $error("queue fill above depth");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> pend_v_q)
		else $error("emitted result not held");

	a_finish_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !pend_v_q)
		else $error("held result left after sample finished");

	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && pend_v_q) |=> (res_v_q && !res_last_q))
		else $error("result followed by another marked as last");

endmodule
`default_nettype wire

// ===== src/midi_clock_transport_generator_top.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------------
// request  | item_valid / item_ready | req_type, start_delay
// result   | result_valid / ready    | status_byte, data_one, data_two,
//          |                         | byte_count, last_in_run
// config   | APB psel/penable/pwrite | paddr (0 tick_period, 8 clock_enable)
//
// Sample request: accept, decode, one message out per step (up to five), then
// a closing step that steps the sample counter. Start goes on to PUSH_A and
// PUSH_B, resume to R_POS and R_CONT; stop, pause and others end at decode.
// Each message waits on the result register; a stalled consumer holds the
// sequencer, but a new request is taken while the last result still waits.
// arst_n clears times, flags, queue pointers; anchor, phase, entries need none.
`default_nettype none
module midi_clock_transport_generator_top (
	input  wire                          clk,
	input  wire                          arst_n,
	// request channel
	input  wire                          item_valid,
	output logic                         item_ready,
	input  wire  [2:0]                   req_type,
	input  wire  [15:0]                  start_delay,
	// result channel
	output logic                         result_valid,
	input  wire                          result_ready,
	output logic [7:0]                   status_byte,
	output logic [6:0]                   data_one,
	output logic [6:0]                   data_two,
	output logic [1:0]                   byte_count,
	output logic                         last_in_run,
	// configuration
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [mctg_pkg::ADDR_W-1:0]  paddr,
	input  wire  [mctg_pkg::DATA_W-1:0]  pwdata,
	output logic [mctg_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	// tick period in Q24.16 samples, start gate
	logic [mctg_pkg::PERIOD_BITS-1:0] tick_period;
	logic                             clock_enable;

	// sequencer to datapath
	mctg_pkg::cmd_t  cmd;
	mctg_pkg::stat_t stat;

	mctg_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.tick_period  (tick_period),
		.clock_enable (clock_enable)
	);

	// sequencer: decodes each request and paces the message drain
	mctg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: sample time, tick time, transport queue, result register
	mctg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.start_delay  (start_delay),
		.tick_period  (tick_period),
		.clock_enable (clock_enable),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status_byte  (status_byte),
		.data_one     (data_one),
		.data_two     (data_two),
		.byte_count   (byte_count),
		.last_in_run  (last_in_run)
	);

endmodule
`default_nettype wire
